// ----- src/sli_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sli_pkg: shared types and codes for the sorted list block
// Item structs, status codes, operation codes and the controller command.
// ----------------------------------------------------------------------------
package sli_pkg;

  localparam int DefCapacity = 16;

  localparam int StatusW = 3;
  localparam int CountW  = 5;

  localparam logic KIND_INSERT = 1'b0;
  localparam logic KIND_DELETE = 1'b1;

  localparam logic [StatusW-1:0] ST_INSERTED  = 3'd0;
  localparam logic [StatusW-1:0] ST_DELETED   = 3'd1;
  localparam logic [StatusW-1:0] ST_NOT_FOUND = 3'd2;
  localparam logic [StatusW-1:0] ST_FULL      = 3'd3;
  localparam logic [StatusW-1:0] ST_EMPTY     = 3'd4;

  typedef struct packed {
    logic               kind;
    logic signed [31:0] item_value;
  } in_item_t;

  typedef struct packed {
    logic [StatusW-1:0] status;
    logic [CountW-1:0]  entry_count;
    logic               table_empty;
  } out_item_t;

  // controller to datapath
  typedef struct packed {
    logic load;     // capture the accepted item
    logic compare;  // register per-entry compare results
    logic apply;    // shift table, update count, load result
  } dp_cmd_t;

endpackage

// ----- src/sli_ctrl.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sli_ctrl: sequencer for the sorted list block
// Steps each item through compare and apply, and owns both handshakes.
// ----------------------------------------------------------------------------
module sli_ctrl (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             in_valid_i,
  output logic             in_ready_o,
  output logic             out_valid_o,
  input  logic             out_ready_i,
  output sli_pkg::dp_cmd_t cmd_o
);
  import sli_pkg::*;

  localparam logic [1:0] S_IDLE  = 2'd0;
  localparam logic [1:0] S_CMP   = 2'd1;
  localparam logic [1:0] S_APPLY = 2'd2;

  logic [1:0] state_q, state_d;
  logic       out_valid_q, out_valid_d;
  logic       out_free;
  logic       accept;

  // result register can take a new item this cycle
  assign out_free   = !out_valid_q || out_ready_i;
  assign in_ready_o = (state_q == S_IDLE) || ((state_q == S_APPLY) && out_free);
  assign accept     = in_valid_i && in_ready_o;

  assign cmd_o.load    = accept;
  assign cmd_o.compare = (state_q == S_CMP);
  assign cmd_o.apply   = (state_q == S_APPLY) && out_free;

  always_comb begin
    state_d = state_q;
    case (state_q)
      S_IDLE: begin
        if (accept) state_d = S_CMP;
      end
      S_CMP: begin
        state_d = S_APPLY;
      end
      S_APPLY: begin
        if (out_free) state_d = accept ? S_CMP : S_IDLE;
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_comb begin
    out_valid_d = out_valid_q;
    if (cmd_o.apply) out_valid_d = 1'b1;
    else if (out_ready_i) out_valid_d = 1'b0;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

  assign out_valid_o = out_valid_q;

endmodule

// ----- src/sli_dpath.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sli_dpath: sorted entry row with per-entry compare and shift
// Each cell compares against the item, then shifts up, down or loads it.
// ----------------------------------------------------------------------------
module sli_dpath #(
  parameter int CAPACITY = sli_pkg::DefCapacity
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  sli_pkg::dp_cmd_t   cmd_i,
  input  sli_pkg::in_item_t  in_item_i,
  output sli_pkg::out_item_t out_item_o
);
  import sli_pkg::*;

  localparam int CntW = $clog2(CAPACITY + 1);
  localparam int ExtW = (CntW > CountW) ? CntW : CountW;

  in_item_t                item_q;
  logic signed [31:0]      entry_q [CAPACITY];
  logic signed [31:0]      entry_d [CAPACITY];
  logic [CntW-1:0]         count_q, count_d;
  logic [CAPACITY-1:0]     gt_q, eq_q;   // item > entry, item == entry (live entries)
  out_item_t               out_q, out_d;
  logic                    found;
  logic                    is_full;
  logic                    is_empty;
  logic                    do_ins;
  logic                    do_del;
  logic [ExtW-1:0]         count_ext;

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) item_q <= in_item_i;
  end

  // compare stage: one comparator pair per cell, masked by fill level
  always_ff @(posedge clk_i) begin
    if (cmd_i.compare) begin
      for (int k = 0; k < CAPACITY; k++) begin
        gt_q[k] <= (CntW'(k) < count_q) && (item_q.item_value > entry_q[k]);
        eq_q[k] <= (CntW'(k) < count_q) && (item_q.item_value == entry_q[k]);
      end
    end
  end

  assign found    = |eq_q;
  assign is_full  = (count_q == CntW'(CAPACITY));
  assign is_empty = (count_q == '0);
  assign do_ins   = (item_q.kind == KIND_INSERT) && !is_full;
  assign do_del   = (item_q.kind == KIND_DELETE) && !is_empty && found;

  // gt_q is a run of ones then zeros, so the insert point is where it falls
  always_comb begin
    for (int k = 0; k < CAPACITY; k++) entry_d[k] = entry_q[k];
    if (do_ins) begin
      if (!gt_q[0]) entry_d[0] = item_q.item_value;
      for (int k = 1; k < CAPACITY; k++) begin
        if (!gt_q[k]) entry_d[k] = gt_q[k-1] ? item_q.item_value : entry_q[k-1];
      end
    end else if (do_del) begin
      for (int k = 0; k + 1 < CAPACITY; k++) begin
        if (!gt_q[k]) entry_d[k] = entry_q[k+1];
      end
    end
  end

  always_comb begin
    count_d = count_q;
    if (do_ins) count_d = count_q + 1'b1;
    else if (do_del) count_d = count_q - 1'b1;
  end

  assign count_ext = ExtW'(count_d);

  always_comb begin
    out_d.entry_count = count_ext[CountW-1:0];
    out_d.table_empty = (count_d == '0);
    if (item_q.kind == KIND_INSERT) begin
      out_d.status = is_full ? ST_FULL : ST_INSERTED;
    end else if (is_empty) begin
      out_d.status = ST_EMPTY;
    end else begin
      out_d.status = found ? ST_DELETED : ST_NOT_FOUND;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.apply) begin
      for (int k = 0; k < CAPACITY; k++) entry_q[k] <= entry_d[k];
      out_q <= out_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) count_q <= '0;
    else if (cmd_i.apply) count_q <= count_d;
  end

  assign out_item_o = out_q;

endmodule

// ----- src/sorted_list_insert_delete.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sorted_list_insert_delete: bounded ascending table of signed values
// Insert ahead of the first entry not smaller, delete the first equal entry.
// ----------------------------------------------------------------------------
//   channel | direction | handshake              | payload
//   in      | input     | in_valid_i / in_ready_o  | in_item_i  (kind, item_value)
//   out     | output    | out_valid_o / out_ready_i | out_item_o (status, count, empty)
//
// Each item passes a compare step, which registers the per-entry compares,
// and an apply step, which shifts the entry row and loads the result register.
// A draining result side lets the next item be taken during the apply step.
// Reset clears the entry count; entry contents are don't-care until written.
// A result waiting on out_ready_i holds the apply step; one new item may be
// taken and compared meanwhile, then no more until the waiting result leaves.
// ----------------------------------------------------------------------------
module sorted_list_insert_delete #(
  parameter int CAPACITY = sli_pkg::DefCapacity
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_ready_o,
  input  sli_pkg::in_item_t  in_item_i,
  output logic               out_valid_o,
  input  logic               out_ready_i,
  output sli_pkg::out_item_t out_item_o
);
  import sli_pkg::*;

  dp_cmd_t cmd;

  sli_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .cmd_o       (cmd)
  );

  sli_dpath #(
    .CAPACITY (CAPACITY)
  ) u_dpath (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cmd_i      (cmd),
    .in_item_i  (in_item_i),
    .out_item_o (out_item_o)
  );

  // an accepted item always passes through compare, where no input is taken
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && in_ready_o) |=> !in_ready_o)
    else $error("input taken during compare step");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && (out_item_o.status == ST_INSERTED)) |-> !out_item_o.table_empty)
    else $error("empty flag set after insert");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && (out_item_o.status == ST_EMPTY)) |-> out_item_o.table_empty)
    else $error("empty status with entries left");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (out_item_o.status == ST_INSERTED || out_item_o.status == ST_DELETED ||
                     out_item_o.status == ST_NOT_FOUND || out_item_o.status == ST_FULL ||
                     out_item_o.status == ST_EMPTY))
    else $error("undefined status code");

endmodule

// ----- tb/sli_checker.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sli_checker: prediction and result checking for the sorted list block
// Watches both channels, keeps its own sorted table, predicts each result
// from the accepted operations and compares it field by field on arrival.
// ----------------------------------------------------------------------------
module sli_checker #(
  parameter int CAPACITY = sli_pkg::DefCapacity
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  input  logic               in_ready_i,
  input  sli_pkg::in_item_t  in_item_i,
  input  logic               out_valid_i,
  input  logic               out_ready_i,
  input  sli_pkg::out_item_t out_item_i,
  output int unsigned        mismatch_count_o,
  output int unsigned        awaited_count_o
);
  import sli_pkg::*;

  logic signed [31:0] table_vals [CAPACITY];
  int unsigned        n_stored;
  out_item_t          awaited_results [$];

  initial begin
    n_stored         = 0;
    mismatch_count_o = 0;
    awaited_count_o  = 0;
  end

  // Applies one operation to the shadow table and returns the outcome.
  function automatic out_item_t apply_table_op(in_item_t op);
    int unsigned pos;
    out_item_t   res;
    pos = 0;
    if (op.kind == KIND_INSERT) begin
      if (n_stored >= CAPACITY) begin
        res.status = ST_FULL;
      end else begin
        // new value goes ahead of equal ones
        while (pos < n_stored && op.item_value > table_vals[pos]) pos++;
        for (int unsigned k = n_stored; k > pos; k--) table_vals[k] = table_vals[k-1];
        table_vals[pos] = op.item_value;
        n_stored++;
        res.status = ST_INSERTED;
      end
    end else if (n_stored == 0) begin
      res.status = ST_EMPTY;
    end else begin
      while (pos < n_stored && table_vals[pos] != op.item_value) pos++;
      if (pos < n_stored) begin
        for (int unsigned k = pos; k + 1 < n_stored; k++) table_vals[k] = table_vals[k+1];
        n_stored--;
        res.status = ST_DELETED;
      end else begin
        res.status = ST_NOT_FOUND;
      end
    end
    res.entry_count = n_stored[CountW-1:0];
    res.table_empty = (n_stored == 0);
    return res;
  endfunction

  task automatic note_failure(string what, out_item_t want, out_item_t got);
    mismatch_count_o++;
    if (mismatch_count_o <= 10) begin
      $display("%0t ns: %s: exp st=%0d cnt=%0d emp=%0d, got st=%0d cnt=%0d emp=%0d",
               $realtime, what, want.status, want.entry_count, want.table_empty,
               got.status, got.entry_count, got.table_empty);
    end
  endtask

  always @(posedge clk_i) begin : monitor
    out_item_t want;
    if (rst_ni) begin
      // result side first: a result never belongs to an item taken at the same edge
      if (out_valid_i && out_ready_i) begin
        if (awaited_results.size() == 0) begin
          note_failure("unexpected result", '0, out_item_i);
        end else begin
          want = awaited_results.pop_front();
          if (out_item_i.status !== want.status ||
              out_item_i.entry_count !== want.entry_count ||
              out_item_i.table_empty !== want.table_empty) begin
            note_failure("result mismatch", want, out_item_i);
          end
        end
      end
      if (in_valid_i && in_ready_i) awaited_results.push_back(apply_table_op(in_item_i));
      awaited_count_o = awaited_results.size();
    end
  end

endmodule

// ----- tb/tb_top.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top: stimulus and verdict for the sorted list block
// Directed corner items, then random insert/delete runs over a mostly small value
// pool with random gaps and stalls on both channels and one long hold-off.
// ----------------------------------------------------------------------------
module tb_top;
  import sli_pkg::*;

  localparam int NumRandom  = 800;
  localparam int IdleLimit  = 2000;
  localparam int HoldCycles = 120;

  logic        clk_i;
  logic        rst_ni;
  logic        in_valid_i;
  logic        in_ready_o;
  in_item_t    in_item_i;
  logic        out_valid_o;
  logic        out_ready_i;
  out_item_t   out_item_o;
  int unsigned mismatch_count;
  int unsigned awaited_count;

  logic        hold_req;
  logic        hold_done;
  int unsigned idle_cycles;

  sorted_list_insert_delete dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .in_item_i  (in_item_i),
    .out_valid_o(out_valid_o),
    .out_ready_i(out_ready_i),
    .out_item_o (out_item_o)
  );

  sli_checker u_checker (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .in_valid_i      (in_valid_i),
    .in_ready_i      (in_ready_o),
    .in_item_i       (in_item_i),
    .out_valid_i     (out_valid_o),
    .out_ready_i     (out_ready_i),
    .out_item_i      (out_item_o),
    .mismatch_count_o(mismatch_count),
    .awaited_count_o (awaited_count)
  );

  always begin
    clk_i = 1'b0;
    #1;
    clk_i = 1'b1;
    #1;
  end

  // mostly short gaps, a few long ones
  function automatic int pick_gap(bit idle_on);
    int r;
    r = $urandom_range(0, 99);
    if (!idle_on || r < 60) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(10, 40);
  endfunction

  // small pool for most picks so deletes hit and duplicates pile up
  function automatic logic signed [31:0] pick_value();
    int r;
    r = $urandom_range(0, 9);
    case (r)
      0:       return 32'sh80000000;
      1:       return 32'sh7fffffff;
      2, 3, 4: return $signed($urandom_range(0, 11)) - 6;
      5, 6:    return $signed($urandom_range(0, 3)) * 1000;
      default: return $urandom;
    endcase
  endfunction

  bit send_idle_on;

  task automatic send_op(logic kind, logic signed [31:0] value);
    int gap;
    gap = pick_gap(send_idle_on);
    if (gap > 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(negedge clk_i);
    end
    in_valid_i           <= 1'b1;
    in_item_i.kind       <= kind;
    in_item_i.item_value <= value;
    do @(posedge clk_i); while (!in_ready_o);
    @(negedge clk_i);
  endtask

  // receiver: random stalls, plus one long hold-off while items keep coming
  initial begin : drain_side
    int  gap;
    bit  idle_on;
    out_ready_i = 1'b0;
    hold_done   = 1'b0;
    idle_on     = 1'b1;
    @(posedge rst_ni);
    forever begin
      @(negedge clk_i);
      if ($urandom_range(0, 63) == 0) idle_on = ($urandom_range(0, 2) != 0);
      if (hold_req && !hold_done) begin
        gap       = HoldCycles;
        hold_done = 1'b1;
      end else begin
        gap = pick_gap(idle_on);
      end
      if (gap > 0) begin
        out_ready_i <= 1'b0;
        repeat (gap) @(negedge clk_i);
      end
      out_ready_i <= 1'b1;
    end
  end

  always @(posedge clk_i) begin
    if (!rst_ni || (in_valid_i && in_ready_o) || (out_valid_o && out_ready_i)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= IdleLimit) begin
      $display("Test completed with failures");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  initial begin : feed_side
    int insert_pct;
    rst_ni       = 1'b0;
    in_valid_i   = 1'b0;
    in_item_i    = '0;
    hold_req     = 1'b0;
    idle_cycles  = 0;
    send_idle_on = 1'b1;
    repeat (11) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    // delete from an empty table, extremes, duplicates, absent value
    send_op(KIND_DELETE, 32'sd0);
    send_op(KIND_INSERT, 32'sh7fffffff);
    send_op(KIND_INSERT, 32'sh80000000);
    send_op(KIND_INSERT, 32'sd0);
    send_op(KIND_INSERT, -32'sd1);
    send_op(KIND_INSERT, 32'sd0);
    send_op(KIND_DELETE, 32'sd5);
    send_op(KIND_DELETE, 32'sd0);
    // fill up, then insert into a full table
    for (int i = 0; i < 12; i++) send_op(KIND_INSERT, 3 * i - 10);
    send_op(KIND_INSERT, 32'sd42);
    send_op(KIND_DELETE, 32'sh80000000);
    send_op(KIND_DELETE, 32'sh7fffffff);

    insert_pct = 50;
    for (int n = 0; n < NumRandom; n++) begin
      // runs biased toward filling or draining the table
      if (n % 32 == 0) begin
        case ($urandom_range(0, 4))
          0:       insert_pct = 10;
          1:       insert_pct = 25;
          2:       insert_pct = 50;
          3:       insert_pct = 75;
          default: insert_pct = 90;
        endcase
      end
      if (n % 50 == 0) send_idle_on = ($urandom_range(0, 2) != 0);
      if (n == 200) begin
        hold_req     = 1'b1;
        send_idle_on = 1'b0;
      end
      if ($urandom_range(0, 99) < insert_pct) send_op(KIND_INSERT, pick_value());
      else send_op(KIND_DELETE, pick_value());
    end
    in_valid_i <= 1'b0;

    wait (awaited_count == 0);
    repeat (20) @(posedge clk_i);
    if (mismatch_count == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule

// ----- sorted_list_insert_delete.f -----
src/sli_pkg.sv
src/sli_ctrl.sv
src/sli_dpath.sv
src/sorted_list_insert_delete.sv
tb/sli_checker.sv
tb/tb_top.sv
